// ===== rtl/timer_task_priority_queue_unit_defines.svh =====
// assertion macros for the timer task priority queue checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef TIMER_TASK_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define TIMER_TASK_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define TTPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ttpq_pkg.sv =====
// shared types and constants for the timer task priority queue
// no dependencies
package ttpq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    localparam int TIME_W    = 64;
    localparam int ID_IN_W   = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REM_HD  = 3'd1,
        OP_REM_IDX = 3'd2,
        OP_RESCHED = 3'd3,
        OP_READ    = 3'd4,
        OP_CLEAR   = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/ttpq_ctrl.sv =====
// controller for the timer task priority queue: handshake and sequencing
// depends on ttpq_pkg
module ttpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ttpq_pkg::t_cmd o_cmd
);

    ttpq_pkg::t_state r_state;
    ttpq_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ttpq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ttpq_pkg::ST_EXEC;
                end
            end
            ttpq_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = ttpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            ttpq_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ttpq_pkg::ST_EXEC: begin
                o_cmd.exec = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttpq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/ttpq_dp.sv =====
// datapath for the timer task priority queue: sorted slot array with
// per-slot compare, shift insert and shift remove, result registers
// depends on ttpq_pkg
module ttpq_dp #(
    parameter int DEPTH   = ttpq_pkg::DEPTH_DEF,
    parameter int ID_BITS = ttpq_pkg::ID_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ttpq_pkg::t_cmd                       i_cmd,
    input  logic [ttpq_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [ttpq_pkg::TIME_W-1:0]   i_task_time,
    input  logic [ttpq_pkg::ID_IN_W-1:0]         i_task_id,
    input  logic [ttpq_pkg::IDX_W-1:0]           i_index,
    output logic signed [ttpq_pkg::TIME_W-1:0]   o_head_time,
    output logic [ttpq_pkg::ID_IN_W-1:0]         o_head_id,
    output logic [ttpq_pkg::CNT_OUT_W-1:0]       o_count,
    output logic                                 o_empty_res,
    output logic signed [ttpq_pkg::TIME_W-1:0]   o_read_time,
    output logic [ttpq_pkg::ID_IN_W-1:0]         o_read_id,
    output logic [ttpq_pkg::STAT_W-1:0]          o_status
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int W    = (CW > ttpq_pkg::IDX_W) ? CW : ttpq_pkg::IDX_W;
    localparam int RD_N = (DEPTH < (1 << ttpq_pkg::IDX_W)) ? DEPTH : (1 << ttpq_pkg::IDX_W);
    localparam int TW   = ttpq_pkg::TIME_W;

    // latched operation
    ttpq_pkg::t_opcode           r_op;
    logic signed [TW-1:0]        r_time;
    logic [ID_BITS-1:0]          r_id;
    logic [ttpq_pkg::IDX_W-1:0]  r_idx;

    // sorted slots
    logic signed [TW-1:0]        r_slot_time [DEPTH];
    logic [ID_BITS-1:0]          r_slot_id   [DEPTH];
    logic signed [TW-1:0]        n_slot_time [DEPTH];
    logic [ID_BITS-1:0]          n_slot_id   [DEPTH];
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;

    // result registers
    logic signed [TW-1:0]        r_head_time;
    logic [ttpq_pkg::ID_IN_W-1:0] r_head_id;
    logic [ttpq_pkg::CNT_OUT_W-1:0] r_cnt_out;
    logic                        r_empty;
    logic signed [TW-1:0]        r_rd_time;
    logic [ttpq_pkg::ID_IN_W-1:0] r_rd_id;
    ttpq_pkg::t_status           r_status;

    logic [DEPTH-1:0]            v_hit;
    logic signed [TW-1:0]        v_rd_time;
    logic [ID_BITS-1:0]          v_rd_id;
    ttpq_pkg::t_status           v_status;
    logic [ID_BITS-1:0]          v_new_id;
    logic                        v_idx_ok;

    // new time sorts before a held slot
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            v_hit[k] = (CW'(k) < r_count) && (r_time < r_slot_time[k]);
        end
    end

    assign v_idx_ok = W'(r_idx) < W'(r_count);
    assign v_new_id = (r_op == ttpq_pkg::OP_RESCHED) ? r_slot_id[0] : r_id;

    always_comb begin
        n_slot_time = r_slot_time;
        n_slot_id   = r_slot_id;
        n_count     = r_count;
        v_status    = ttpq_pkg::STAT_OK;
        v_rd_time   = '0;
        v_rd_id     = '0;
        case (r_op)
            ttpq_pkg::OP_INSERT: begin
                if (r_count == CW'(DEPTH)) begin
                    v_status = ttpq_pkg::STAT_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    for (int k = 0; k < DEPTH; k++) begin
                        if (k > 0 && v_hit[(k > 0) ? k - 1 : 0]) begin
                            n_slot_time[k] = r_slot_time[(k > 0) ? k - 1 : 0];
                            n_slot_id[k]   = r_slot_id[(k > 0) ? k - 1 : 0];
                        end else if (v_hit[k] || CW'(k) == r_count) begin
                            n_slot_time[k] = r_time;
                            n_slot_id[k]   = v_new_id;
                        end
                    end
                end
            end
            ttpq_pkg::OP_REM_HD, ttpq_pkg::OP_REM_IDX: begin
                if (r_count == '0) begin
                    v_status = ttpq_pkg::STAT_EMPTY;
                end else if (r_op == ttpq_pkg::OP_REM_IDX && !v_idx_ok) begin
                    v_status = ttpq_pkg::STAT_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        if (r_op == ttpq_pkg::OP_REM_HD || W'(k) >= W'(r_idx)) begin
                            n_slot_time[k] = r_slot_time[k + 1];
                            n_slot_id[k]   = r_slot_id[k + 1];
                        end
                    end
                end
            end
            ttpq_pkg::OP_RESCHED: begin
                if (r_count == '0) begin
                    v_status = ttpq_pkg::STAT_EMPTY;
                end else begin
                    for (int k = 0; k < DEPTH; k++) begin
                        if (k > 0 && v_hit[k]) begin
                            n_slot_time[k] = r_slot_time[k];
                            n_slot_id[k]   = r_slot_id[k];
                        end else if ((k < DEPTH - 1 && v_hit[(k < DEPTH - 1) ? k + 1 : k])
                                     || CW'(k) == r_count - CW'(1)) begin
                            n_slot_time[k] = r_time;
                            n_slot_id[k]   = v_new_id;
                        end else if (k < DEPTH - 1) begin
                            n_slot_time[k] = r_slot_time[(k < DEPTH - 1) ? k + 1 : k];
                            n_slot_id[k]   = r_slot_id[(k < DEPTH - 1) ? k + 1 : k];
                        end
                    end
                end
            end
            ttpq_pkg::OP_READ: begin
                if (!v_idx_ok) begin
                    v_status = ttpq_pkg::STAT_RANGE;
                end else begin
                    for (int k = 0; k < RD_N; k++) begin
                        if (r_idx == ttpq_pkg::IDX_W'(k)) begin
                            v_rd_time = r_slot_time[k];
                            v_rd_id   = r_slot_id[k];
                        end
                    end
                end
            end
            ttpq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                v_status = ttpq_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= ttpq_pkg::t_opcode'(i_opcode);
            r_time <= i_task_time;
            r_id   <= ID_BITS'(i_task_id);
            r_idx  <= i_index;
        end
        if (i_cmd.exec) begin
            r_slot_time <= n_slot_time;
            r_slot_id   <= n_slot_id;
            r_head_time <= (n_count != '0) ? n_slot_time[0] : '0;
            r_head_id   <= (n_count != '0) ? ttpq_pkg::ID_IN_W'(n_slot_id[0]) : '0;
            r_cnt_out   <= ttpq_pkg::CNT_OUT_W'(n_count);
            r_empty     <= (n_count == '0);
            r_rd_time   <= v_rd_time;
            r_rd_id     <= ttpq_pkg::ID_IN_W'(v_rd_id);
            r_status    <= v_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_head_time = r_head_time;
    assign o_head_id   = r_head_id;
    assign o_count     = r_cnt_out;
    assign o_empty_res = r_empty;
    assign o_read_time = r_rd_time;
    assign o_read_id   = r_rd_id;
    assign o_status    = r_status;

endmodule

// ===== rtl/timer_task_priority_queue_unit.sv =====
// top level of the timer task priority queue
// depends on ttpq_pkg, ttpq_ctrl, ttpq_dp
//
// channel  direction  handshake                     payload
// in       input      i_in_valid / o_in_stall       opcode, task_time, task_id, index
// out      output     o_out_valid / i_out_stall     head, count, empty, read entry, status
//
// each beat is captured in the idle state, then the slot array is updated in the execute state
// the compare and shift across all slots is combinational
// one beat is worked on at a time; the next can be taken while a result waits
// reset empties the queue and drops any pending result
// a stalled result holds the next update in the execute state
module timer_task_priority_queue_unit #(
    parameter int DEPTH   = ttpq_pkg::DEPTH_DEF,
    parameter int ID_BITS = ttpq_pkg::ID_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ttpq_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [ttpq_pkg::TIME_W-1:0]   i_task_time,
    input  logic [ttpq_pkg::ID_IN_W-1:0]         i_task_id,
    input  logic [ttpq_pkg::IDX_W-1:0]           i_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [ttpq_pkg::TIME_W-1:0]   o_head_time,
    output logic [ttpq_pkg::ID_IN_W-1:0]         o_head_id,
    output logic [ttpq_pkg::CNT_OUT_W-1:0]       o_count,
    output logic                                 o_empty_res,
    output logic signed [ttpq_pkg::TIME_W-1:0]   o_read_time,
    output logic [ttpq_pkg::ID_IN_W-1:0]         o_read_id,
    output logic [ttpq_pkg::STAT_W-1:0]          o_status
);

    ttpq_pkg::t_cmd cmd;

    ttpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ttpq_dp #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (i_opcode),
        .i_task_time (i_task_time),
        .i_task_id   (i_task_id),
        .i_index     (i_index),
        .o_head_time (o_head_time),
        .o_head_id   (o_head_id),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_read_time (o_read_time),
        .o_read_id   (o_read_id),
        .o_status    (o_status)
    );

endmodule

// ===== rtl/ttpq_chk.sv =====
// port-level checker for the timer task priority queue, bound to the top level
// depends on ttpq_pkg and timer_task_priority_queue_unit_defines.svh
`include "timer_task_priority_queue_unit_defines.svh"

module ttpq_chk #(
    parameter int DEPTH = ttpq_pkg::DEPTH_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic [ttpq_pkg::OP_W-1:0]            i_opcode,
    input logic signed [ttpq_pkg::TIME_W-1:0]   i_task_time,
    input logic [ttpq_pkg::ID_IN_W-1:0]         i_task_id,
    input logic [ttpq_pkg::IDX_W-1:0]           i_index,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [ttpq_pkg::TIME_W-1:0]   o_head_time,
    input logic [ttpq_pkg::ID_IN_W-1:0]         o_head_id,
    input logic [ttpq_pkg::CNT_OUT_W-1:0]       o_count,
    input logic                                 o_empty_res,
    input logic signed [ttpq_pkg::TIME_W-1:0]   o_read_time,
    input logic [ttpq_pkg::ID_IN_W-1:0]         o_read_id,
    input logic [ttpq_pkg::STAT_W-1:0]          o_status
);

    `TTPQ_ASSERT_NOW(a_empty_head, o_out_valid && o_empty_res, o_head_time == '0 && o_head_id == '0, "empty queue reports a head")
    `TTPQ_ASSERT_NOW(a_fail_no_read, o_out_valid && o_status != ttpq_pkg::STAT_OK, o_read_time == '0 && o_read_id == '0, "failed beat carries read data")
    `TTPQ_ASSERT_NOW(a_full_count, o_out_valid && o_status == ttpq_pkg::STAT_FULL, o_count == ttpq_pkg::CNT_OUT_W'(DEPTH) && !o_empty_res, "full status with wrong count")
    `TTPQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_head_time) && $stable(o_count) && $stable(o_status), "stalled result changed")
    `TTPQ_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_opcode) && $stable(i_task_time) && $stable(i_task_id) && $stable(i_index), "stalled input beat changed")

endmodule

bind timer_task_priority_queue_unit ttpq_chk #(.DEPTH(DEPTH)) u_ttpq_chk (.*);
